[hdl/dmps_pkg.sv]
// Shared phase codes, register indexes, constants and types of the door motion sequencer.
`timescale 1ns / 1ps
`default_nettype none
package dmps_pkg;

	localparam int PHASE_W = 4;
	localparam int STEP_W  = 8;
	localparam int CFG_IDX_W = 3;

	localparam logic [PHASE_W-1:0] PH_REST       = 4'd0;
	localparam logic [PHASE_W-1:0] PH_OPEN_ACC   = 4'd1;
	localparam logic [PHASE_W-1:0] PH_OPEN_CON   = 4'd2;
	localparam logic [PHASE_W-1:0] PH_OPEN_DEC   = 4'd3;
	localparam logic [PHASE_W-1:0] PH_OPEN_ZERO  = 4'd4;
	localparam logic [PHASE_W-1:0] PH_STANDBY    = 4'd5;
	localparam logic [PHASE_W-1:0] PH_CLOSE_ACC  = 4'd6;
	localparam logic [PHASE_W-1:0] PH_CLOSE_CON  = 4'd7;
	localparam logic [PHASE_W-1:0] PH_CLOSE_DEC  = 4'd8;
	localparam logic [PHASE_W-1:0] PH_CLOSE_ZERO = 4'd9;
	localparam logic [PHASE_W-1:0] PH_EMERGENCY  = 4'd10;

	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_HOLD       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_ACCELERATE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_CONSTANT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DECELERATE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_ZERO_HOLD  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_EMERGENCY  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_EMERGENCY_POSE  = 3'd6;

	localparam logic [15:0]        GAIN_RESET = 16'd256;
	localparam logic signed [16:0] RAMP_STEP  = 17'sd614;
	localparam logic signed [16:0] TOLERANCE  = 17'sd205;
	localparam logic [STEP_W-1:0]  STEP_MAX   = 8'd255;

	typedef struct packed {
		logic [15:0]        gain;
		logic signed [16:0] err;
	} effort_req_t;

endpackage
`default_nettype wire

[hdl/dmps_if.sv]
// Handshake channels of the door motion sequencer: sample, result and register write.
`timescale 1ns / 1ps
`default_nettype none
interface dmps_sample_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] pose_sample;
	logic signed [15:0] velocity_sample;
	logic               button_pressed;
	logic               obstacle_sensed;
	modport source (output valid, pose_sample, velocity_sample, button_pressed,
		obstacle_sensed, input ready);
	modport sink (input valid, pose_sample, velocity_sample, button_pressed,
		obstacle_sensed, output ready);
endinterface

interface dmps_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] drive_effort;
	logic [3:0]         phase_code;
	logic signed [15:0] speed_target;
	modport source (output valid, drive_effort, phase_code, speed_target, input ready);
	modport sink (input valid, drive_effort, phase_code, speed_target, output ready);
endinterface

interface dmps_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hdl/dmps_effort.sv]
// Proportional effort: gain times error, round half up, saturate to Q4.12.
`timescale 1ns / 1ps
`default_nettype none
module dmps_effort
	import dmps_pkg::*;
(
	input  effort_req_t        req,
	output logic signed [15:0] effort
);

	logic signed [33:0] prod;
	logic signed [33:0] rnd;
	logic signed [33:0] shr;

	always_comb begin
		prod = $signed({1'b0, req.gain}) * req.err;
		rnd  = prod + 34'sd128;
		shr  = rnd >>> 8;
		if (shr > 34'sd32767) begin
			effort = 16'sh7FFF;
		end else if (shr < -34'sd32768) begin
			effort = -16'sh8000;
		end else begin
			effort = shr[15:0];
		end
	end

endmodule
`default_nettype wire

[hdl/door_motion_profile_sequencer.sv]
// Top level of the door motion profile sequencer.
//
// Channels: sample carries one control tick (pose, velocity, button, obstacle);
// result returns one word per tick (drive effort, phase after the tick, speed
// target after the tick); cfg writes gains and the emergency pose, always ready.
// Path: an accepted sample is registered in the stage-one register, then in the
// result register, from which the word leaves.
// Throughput: one tick per cycle while result does not stall. The phase, step
// counter and target update at the accepting edge; the effort multiply sits in
// the second stage, between the stage-one register and the result register.
// Stall: with result stalled, the stage-one word and the result word are held
// and sample.ready drops only when both are full.
// Reset: phase rest, step count and target zero, all gains 256, emergency pose
// zero, no word in flight.
// Write registers only while no tick is in flight.
`timescale 1ns / 1ps
`default_nettype none
module door_motion_profile_sequencer
	import dmps_pkg::*;
#(
	parameter int ACCEL_STEPS     = 16,
	parameter int CONSTANT_STEPS  = 32,
	parameter int DECEL_STEPS     = 16,
	parameter int ZERO_HOLD_STEPS = 8
) (
	input wire logic       clk,
	input wire logic       arst_n,
	dmps_sample_if.sink    sample,
	dmps_result_if.source  result,
	dmps_cfg_if.sink       cfg
);

	localparam logic [STEP_W-1:0] ACC_LIM  = STEP_W'(ACCEL_STEPS);
	localparam logic [STEP_W-1:0] CON_LIM  = STEP_W'(CONSTANT_STEPS);
	localparam logic [STEP_W-1:0] DEC_LIM  = STEP_W'(DECEL_STEPS);
	localparam logic [STEP_W-1:0] ZERO_LIM = STEP_W'(ZERO_HOLD_STEPS);

	logic [15:0]        gain_hold_q, gain_acc_q, gain_con_q, gain_dec_q;
	logic [15:0]        gain_zero_q, gain_emg_q;
	logic signed [15:0] emg_pose_q;

	logic [PHASE_W-1:0] phase_q;
	logic [STEP_W-1:0]  step_q;
	logic signed [15:0] target_q;

	logic [PHASE_W-1:0] phase_n;
	logic [STEP_W-1:0]  step_n;
	logic signed [15:0] target_n;
	effort_req_t        req_n;

	logic               vld_s1;
	effort_req_t        req_s1;
	logic [PHASE_W-1:0] phase_s1;
	logic signed [15:0] target_s1;

	logic               vld_s2;
	logic signed [15:0] effort_s2;
	logic [PHASE_W-1:0] phase_s2;
	logic signed [15:0] target_s2;

	logic               adv_s2;
	logic               take;
	logic signed [15:0] effort_c;

	function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
		input logic signed [16:0] d);
		logic signed [16:0] s;
		s = 17'(a) + d;
		if (s > 17'sd32767) begin
			return 16'sh7FFF;
		end else if (s < -17'sd32768) begin
			return -16'sh8000;
		end
		return s[15:0];
	endfunction

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_hold_q <= GAIN_RESET;
			gain_acc_q  <= GAIN_RESET;
			gain_con_q  <= GAIN_RESET;
			gain_dec_q  <= GAIN_RESET;
			gain_zero_q <= GAIN_RESET;
			gain_emg_q  <= GAIN_RESET;
			emg_pose_q  <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_GAIN_HOLD:       gain_hold_q <= cfg.data;
				CFG_GAIN_ACCELERATE: gain_acc_q  <= cfg.data;
				CFG_GAIN_CONSTANT:   gain_con_q  <= cfg.data;
				CFG_GAIN_DECELERATE: gain_dec_q  <= cfg.data;
				CFG_GAIN_ZERO_HOLD:  gain_zero_q <= cfg.data;
				CFG_GAIN_EMERGENCY:  gain_emg_q  <= cfg.data;
				CFG_EMERGENCY_POSE:  emg_pose_q  <= $signed(cfg.data);
				default: begin
				end
			endcase
		end
	end

	assign adv_s2       = !vld_s2 || result.ready;
	assign sample.ready = !vld_s1 || adv_s2;
	assign take         = sample.valid && sample.ready;

	always_comb begin
		logic               closing;
		logic               emg;
		logic               open_dir;
		logic signed [15:0] up;
		logic signed [15:0] dn;
		logic signed [16:0] dp;
		logic signed [16:0] vel;
		logic [STEP_W-1:0]  bump;
		logic [15:0]        gain;

		closing  = (phase_q >= PH_CLOSE_ACC) && (phase_q <= PH_CLOSE_ZERO);
		open_dir = (phase_q <= PH_OPEN_ZERO);
		up       = sat_add(target_q, RAMP_STEP);
		dn       = sat_add(target_q, -RAMP_STEP);
		vel      = 17'(sample.velocity_sample);
		dp       = 17'(sample.pose_sample) - 17'(emg_pose_q);
		bump     = (step_q < STEP_MAX) ? step_q + 1'b1 : step_q;
		phase_n  = phase_q;
		step_n   = step_q;
		target_n = target_q;
		gain     = '0;
		emg      = 1'b0;

		if (closing && sample.obstacle_sensed) begin
			phase_n  = PH_EMERGENCY;
			target_n = '0;
			gain     = gain_emg_q;
			emg      = 1'b1;
		end else begin
			unique case (phase_q)
				PH_REST, PH_STANDBY: begin
					if (sample.button_pressed &&
						(phase_q == PH_REST || !sample.obstacle_sensed)) begin
						phase_n  = (phase_q == PH_REST) ? PH_OPEN_ACC : PH_CLOSE_ACC;
						target_n = (phase_q == PH_REST) ? up : dn;
						gain     = gain_acc_q;
						step_n   = '0;
					end else begin
						target_n = '0;
						gain     = gain_hold_q;
					end
				end
				PH_OPEN_ACC, PH_CLOSE_ACC: begin
					if (step_q >= ACC_LIM) begin
						phase_n = phase_q + 1'b1;
						gain    = gain_con_q;
						step_n  = '0;
					end else begin
						target_n = open_dir ? up : dn;
						gain     = gain_acc_q;
						step_n   = bump;
					end
				end
				PH_OPEN_CON, PH_CLOSE_CON: begin
					if (step_q >= CON_LIM) begin
						target_n = open_dir ? dn : up;
						phase_n  = phase_q + 1'b1;
						gain     = gain_dec_q;
						step_n   = '0;
					end else begin
						gain   = gain_con_q;
						step_n = bump;
					end
				end
				PH_OPEN_DEC, PH_CLOSE_DEC: begin
					if (step_q >= DEC_LIM) begin
						phase_n  = phase_q + 1'b1;
						target_n = '0;
						gain     = gain_zero_q;
						step_n   = '0;
					end else begin
						target_n = open_dir ? dn : up;
						gain     = gain_dec_q;
						step_n   = bump;
					end
				end
				PH_OPEN_ZERO, PH_CLOSE_ZERO: begin
					target_n = '0;
					if (step_q >= ZERO_LIM) begin
						phase_n = open_dir ? PH_STANDBY : PH_REST;
						gain    = gain_hold_q;
						step_n  = '0;
					end else begin
						gain   = gain_zero_q;
						step_n = bump;
					end
				end
				PH_EMERGENCY: begin
					if (dp >= -TOLERANCE && dp <= TOLERANCE &&
						vel >= -TOLERANCE && vel <= TOLERANCE) begin
						phase_n = PH_STANDBY;
					end else begin
						target_n = '0;
						gain     = gain_emg_q;
						emg      = 1'b1;
					end
				end
				default: begin
					phase_n  = PH_REST;
					target_n = '0;
					step_n   = '0;
				end
			endcase
		end

		req_n.gain = gain;
		req_n.err  = emg ? (17'(emg_pose_q) - 17'(sample.pose_sample))
			: (17'(target_n) - vel);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_REST;
			step_q   <= '0;
			target_q <= '0;
		end else if (take) begin
			phase_q  <= phase_n;
			step_q   <= step_n;
			target_q <= target_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (sample.ready) begin
				vld_s1 <= sample.valid;
			end
			if (adv_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_s1    <= req_n;
			phase_s1  <= phase_n;
			target_s1 <= target_n;
		end
		if (adv_s2 && vld_s1) begin
			effort_s2 <= effort_c;
			phase_s2  <= phase_s1;
			target_s2 <= target_s1;
		end
	end

	dmps_effort u_effort (
		.req    (req_s1),
		.effort (effort_c)
	);

	assign result.valid        = vld_s2;
	assign result.drive_effort = effort_s2;
	assign result.phase_code   = phase_s2;
	assign result.speed_target = target_s2;

endmodule
`default_nettype wire

[hdl/dmps_checker.sv]
// Port-level checks of the door motion sequencer, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none
module dmps_checker
	import dmps_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic signed [15:0] out_effort,
	input wire logic [3:0]         out_phase,
	input wire logic signed [15:0] out_target
);

	a_hold_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_effort) &&
		$stable(out_phase) && $stable(out_target))
		else $error("result word changed while stalled");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("sample stalled with result side free");

	a_zero_target: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_phase == PH_REST || out_phase == PH_STANDBY ||
		out_phase == PH_OPEN_ZERO || out_phase == PH_CLOSE_ZERO ||
		out_phase == PH_EMERGENCY) |-> out_target == 16'sd0)
		else $error("nonzero target in a holding phase");

	a_phase_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_phase <= PH_EMERGENCY)
		else $error("phase code out of range");

endmodule

bind door_motion_profile_sequencer dmps_checker u_dmps_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (sample.ready),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.out_effort (result.drive_effort),
	.out_phase  (result.phase_code),
	.out_target (result.speed_target)
);
`default_nettype wire
